// ===== sv/hfds_pkg.sv =====
package hfds_pkg;

  localparam int unsigned DistW = 24;
  localparam int unsigned BandW = 23;
  localparam int unsigned ChiW  = 17;
  localparam int unsigned DiffW = 25;
  localparam int unsigned ProdW = 50;
  localparam int unsigned SumW  = 52;
  localparam int unsigned QBits = 16;
  localparam logic [ChiW-1:0] ChiOne = 17'h10000;

  typedef struct packed {
    logic            sharp;
    logic            sharp_one;
    logic            zero_out;
    logic            one_out;
    logic [SumW:0]   rem;
    logic [SumW-1:0] den;
    logic [QBits-1:0] quo;
  } div_word_t;

endpackage

// ===== sv/heaviside_from_distance_stencil_top.sv =====
// An accepted input word passes through the stage 1, stage 2 and divider-entry registers and then the divider cells.
// Throughput: one word per cycle; the pipeline advances whenever the output stage is free.
// The quotient comes from a row of sixteen restoring divider cells, one bit per cell.
// Reset clears all valid flags and loads band_q with 65536.
// Payload registers are not reset.
module heaviside_from_distance_stencil_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [hfds_pkg::BandW-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [hfds_pkg::DistW-1:0] dist_center_i,
  input  logic signed [hfds_pkg::DistW-1:0] dist_xplus_i,
  input  logic signed [hfds_pkg::DistW-1:0] dist_xminus_i,
  input  logic signed [hfds_pkg::DistW-1:0] dist_yplus_i,
  input  logic signed [hfds_pkg::DistW-1:0] dist_yminus_i,
  input  logic signed [hfds_pkg::DistW-1:0] dist_zplus_i,
  input  logic signed [hfds_pkg::DistW-1:0] dist_zminus_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [hfds_pkg::ChiW-1:0]   chi_value_o,
  output logic                        in_band_o
);

  localparam int unsigned NCells = hfds_pkg::QBits;
  localparam int unsigned NStg   = NCells + 3;

  logic [hfds_pkg::BandW-1:0] band_q;
  logic [NStg-1:0] vld_q;
  logic adv;

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_q <= hfds_pkg::BandW'(65536);
    end else if (cfg_we_i) begin
      band_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], in_valid_i};
    end
  end

  // Stage 1: differences and band test.
  logic signed [hfds_pkg::DiffW-1:0] du_d [3], di_d [3];
  logic signed [hfds_pkg::DiffW-1:0] du_q [3], di_q [3];
  logic signed [hfds_pkg::DistW-1:0] pl [3], mi [3], pc [3], mc [3];
  logic s1_sharp_q, s1_one_q;
  logic signed [hfds_pkg::DistW:0] c_ext, h_ext;

  assign pl[0] = dist_xplus_i;
  assign mi[0] = dist_xminus_i;
  assign pl[1] = dist_yplus_i;
  assign mi[1] = dist_yminus_i;
  assign pl[2] = dist_zplus_i;
  assign mi[2] = dist_zminus_i;
  assign c_ext = {dist_center_i[hfds_pkg::DistW-1], dist_center_i};
  assign h_ext = {2'b00, band_q};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pc[k]   = pl[k][hfds_pkg::DistW-1] ? '0 : pl[k];
      mc[k]   = mi[k][hfds_pkg::DistW-1] ? '0 : mi[k];
      du_d[k] = hfds_pkg::DiffW'(pl[k]) - hfds_pkg::DiffW'(mi[k]);
      di_d[k] = hfds_pkg::DiffW'(pc[k]) - hfds_pkg::DiffW'(mc[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      du_q       <= du_d;
      di_q       <= di_d;
      s1_sharp_q <= (c_ext > h_ext) || (c_ext < -h_ext);
      s1_one_q   <= !dist_center_i[hfds_pkg::DistW-1] && (dist_center_i != '0);
    end
  end

  // Stage 2: products.
  logic signed [hfds_pkg::ProdW-1:0] pn_q [3], pd_q [3];
  logic s2_sharp_q, s2_one_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        pn_q[k] <= hfds_pkg::ProdW'(di_q[k] * du_q[k]);
        pd_q[k] <= hfds_pkg::ProdW'(du_q[k] * du_q[k]);
      end
      s2_sharp_q <= s1_sharp_q;
      s2_one_q   <= s1_one_q;
    end
  end

  // Stage 3: sums, saturation decisions, divider entry.
  logic signed [hfds_pkg::SumW-1:0] num_s, den_s;
  hfds_pkg::div_word_t w_in, w_q;

  always_comb begin
    num_s = hfds_pkg::SumW'(pn_q[0]) + hfds_pkg::SumW'(pn_q[1]) + hfds_pkg::SumW'(pn_q[2]);
    den_s = hfds_pkg::SumW'(pd_q[0]) + hfds_pkg::SumW'(pd_q[1]) + hfds_pkg::SumW'(pd_q[2]);
    w_in.sharp     = s2_sharp_q;
    w_in.sharp_one = s2_one_q;
    w_in.zero_out  = (den_s == '0) || (num_s <= 0);
    w_in.one_out   = num_s >= den_s;
    w_in.rem       = {1'b0, num_s};
    w_in.den       = den_s;
    w_in.quo       = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      w_q <= w_in;
    end
  end

  hfds_pkg::div_word_t chain [NCells+1];
  assign chain[0] = w_q;

  for (genvar g = 0; g < NCells; g++) begin : g_cell
    hfds_div_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .word_i (chain[g]),
      .word_o (chain[g+1])
    );
  end

  hfds_pkg::div_word_t w_out;
  assign w_out = chain[NCells];

  assign out_valid_o = vld_q[NStg-1];
  assign in_band_o   = !w_out.sharp;
  always_comb begin
    if (w_out.sharp) begin
      chi_value_o = w_out.sharp_one ? hfds_pkg::ChiOne : '0;
    end else if (w_out.zero_out) begin
      chi_value_o = '0;
    end else if (w_out.one_out) begin
      chi_value_o = hfds_pkg::ChiOne;
    end else begin
      chi_value_o = {1'b0, w_out.quo};
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(chi_value_o))
    else $error("result changed while stalled");
  a_chi_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> chi_value_o <= hfds_pkg::ChiOne)
    else $error("chi out of range");
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted word lost");

endmodule

// ===== sv/hfds_div_cell.sv =====
module hfds_div_cell (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  hfds_pkg::div_word_t   word_i,
  output hfds_pkg::div_word_t   word_o
);

  hfds_pkg::div_word_t word_d, word_q;
  logic [hfds_pkg::SumW:0] shifted;

  always_comb begin
    word_d  = word_i;
    shifted = {word_i.rem[hfds_pkg::SumW-1:0], 1'b0};
    word_d.quo = {word_i.quo[hfds_pkg::QBits-2:0], 1'b0};
    if (shifted >= {1'b0, word_i.den}) begin
      word_d.rem    = shifted - {1'b0, word_i.den};
      word_d.quo[0] = 1'b1;
    end else begin
      word_d.rem = shifted;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule
